@@ rtl/clrle_pkg.sv @@
package clrle_pkg;

  localparam int LenWidth   = 4;
  localparam int SymWidth   = 5;
  localparam int ExtraWidth = 7;
  localparam int EwWidth    = 3;
  localparam int CountWidth = 8;

  localparam logic [SymWidth-1:0]   SYM_REPEAT     = 5'd16;
  localparam logic [SymWidth-1:0]   SYM_ZERO_SHORT = 5'd17;
  localparam logic [SymWidth-1:0]   SYM_ZERO_LONG  = 5'd18;

  localparam logic [EwWidth-1:0]    EW_REPEAT      = 3'd2;
  localparam logic [EwWidth-1:0]    EW_ZERO_SHORT  = 3'd3;
  localparam logic [EwWidth-1:0]    EW_ZERO_LONG   = 3'd7;

  localparam logic [CountWidth-1:0] REPEAT_MAX     = 8'd6;
  localparam logic [CountWidth-1:0] ZERO_MAX       = 8'd138;
  localparam logic [CountWidth-1:0] SHORT_MIN      = 8'd3;
  localparam logic [CountWidth-1:0] LONG_MIN       = 8'd11;

  typedef enum logic [1:0] {
    KIND_IDLE    = 2'd0,
    KIND_ZERO    = 2'd1,
    KIND_NONZERO = 2'd2
  } kind_t;

  typedef struct packed {
    logic [SymWidth-1:0]   symbol;
    logic [ExtraWidth-1:0] extra_value;
    logic [EwWidth-1:0]    extra_width;
  } entry_t;

  typedef struct packed {
    logic [1:0] cnt;
    entry_t     e0;
    entry_t     e1;
  } flush_t;

  typedef struct packed {
    entry_t e;
    logic   item_done;
    logic   sequence_done;
  } result_t;

  function automatic entry_t literal_f(input logic [LenWidth-1:0] value);
    entry_t r;
    r.symbol      = {1'b0, value};
    r.extra_value = '0;
    r.extra_width = '0;
    return r;
  endfunction

  // symbols that close a pending run
  function automatic flush_t flush_f(input kind_t kind,
                                     input logic [CountWidth-1:0] count,
                                     input logic [LenWidth-1:0] value);
    flush_t f;
    logic [CountWidth-1:0] d_long;
    logic [CountWidth-1:0] d_short;
    d_long  = count - LONG_MIN;
    d_short = count - SHORT_MIN;
    f.cnt = 2'd0;
    f.e0  = literal_f('0);
    f.e1  = literal_f('0);
    unique case (kind)
      KIND_ZERO: begin
        if (count >= LONG_MIN) begin
          f.cnt = 2'd1;
          f.e0.symbol      = SYM_ZERO_LONG;
          f.e0.extra_value = d_long[ExtraWidth-1:0];
          f.e0.extra_width = EW_ZERO_LONG;
        end else if (count >= SHORT_MIN) begin
          f.cnt = 2'd1;
          f.e0.symbol      = SYM_ZERO_SHORT;
          f.e0.extra_value = d_short[ExtraWidth-1:0];
          f.e0.extra_width = EW_ZERO_SHORT;
        end else begin
          f.cnt = count[1:0];
        end
      end
      KIND_NONZERO: begin
        if (count >= SHORT_MIN) begin
          f.cnt = 2'd1;
          f.e0.symbol      = SYM_REPEAT;
          f.e0.extra_value = d_short[ExtraWidth-1:0];
          f.e0.extra_width = EW_REPEAT;
        end else begin
          f.cnt = count[1:0];
          f.e0  = literal_f(value);
          f.e1  = literal_f(value);
        end
      end
      default: begin
        f.cnt = 2'd0;
      end
    endcase
    return f;
  endfunction

endpackage

@@ rtl/clrle_len_if.sv @@
interface clrle_len_if;
  logic                            valid;
  logic                            ready;
  logic [clrle_pkg::LenWidth-1:0]  len_value;
  logic                            last_in;

  modport source (output valid, output len_value, output last_in, input ready);
  modport sink   (input valid, input len_value, input last_in, output ready);
endinterface

@@ rtl/clrle_sym_if.sv @@
interface clrle_sym_if;
  logic                              valid;
  logic                              ready;
  logic [clrle_pkg::SymWidth-1:0]    symbol;
  logic [clrle_pkg::ExtraWidth-1:0]  extra_value;
  logic [clrle_pkg::EwWidth-1:0]     extra_width;
  logic                              item_done;
  logic                              sequence_done;

  modport source (output valid, output symbol, output extra_value, output extra_width,
                  output item_done, output sequence_done, input ready);
  modport sink   (input valid, input symbol, input extra_value, input extra_width,
                  input item_done, input sequence_done, output ready);
endinterface

@@ rtl/code_length_run_length_encoder_unit.sv @@
// channel   dir  payload                                                   items
// lengths   in   len_value, last_in                                        one length
// symbols   out  symbol, extra_value, extra_width, item_done, sequence_done one symbol
//
// an accepted length updates the run state in the same cycle and writes 0..3 symbols
// into an 8-entry result queue; the first symbol is offered the cycle after if the queue was empty
// lengths are taken at one per cycle while at least 3 queue entries are free
// symbols leave at one per cycle, so long stalls on symbols fill the queue and stop input
// rst (synchronous) empties the queue and returns the run state to idle
module code_length_run_length_encoder_unit (
  input logic         clk,
  input logic         rst,
  clrle_len_if.sink   lengths,
  clrle_sym_if.source symbols
);

  localparam int Depth  = 8;
  localparam int PtrW   = $clog2(Depth);
  localparam int CntW   = PtrW + 1;

  clrle_pkg::kind_t                      run_kind, run_kind_next;
  logic [clrle_pkg::CountWidth-1:0]      run_count, run_count_next;
  logic [clrle_pkg::LenWidth-1:0]        run_value, run_value_next;

  clrle_pkg::result_t                    queue [Depth];
  logic [PtrW-1:0]                       wr_ptr;
  logic [PtrW-1:0]                       rd_ptr;
  logic [CntW-1:0]                       fill;

  clrle_pkg::result_t                    res [3];
  logic [1:0]                            n_res;
  logic                                  accept;
  logic                                  pop;

  assign lengths.ready = (fill <= CntW'(Depth - 3));
  assign accept        = lengths.valid & lengths.ready;
  assign pop           = symbols.valid & symbols.ready;

  always_comb begin
    clrle_pkg::kind_t                 k;
    logic [clrle_pkg::CountWidth-1:0] c;
    logic [clrle_pkg::LenWidth-1:0]   rv;
    logic [clrle_pkg::LenWidth-1:0]   v;
    clrle_pkg::flush_t                f;
    logic [1:0]                       n;

    k  = run_kind;
    c  = run_count;
    rv = run_value;
    v  = lengths.len_value;
    n  = 2'd0;
    f  = '0;
    for (int i = 0; i < 3; i++) begin
      res[i].e             = clrle_pkg::literal_f('0);
      res[i].item_done     = 1'b0;
      res[i].sequence_done = 1'b0;
    end
    if (k != clrle_pkg::KIND_ZERO && k != clrle_pkg::KIND_NONZERO) begin
      k = clrle_pkg::KIND_IDLE;
    end

    if (v == '0) begin
      if (k != clrle_pkg::KIND_ZERO) begin
        f = clrle_pkg::flush_f(k, c, rv);
        if (f.cnt >= 2'd1 && n < 2'd3) begin
          res[n].e = f.e0;
          n = n + 2'd1;
        end
        if (f.cnt >= 2'd2 && n < 2'd3) begin
          res[n].e = f.e1;
          n = n + 2'd1;
        end
        k = clrle_pkg::KIND_ZERO;
        c = '0;
      end
      c = c + clrle_pkg::CountWidth'(1);
      if (c >= clrle_pkg::ZERO_MAX) begin
        f = clrle_pkg::flush_f(k, c, rv);
        if (n < 2'd3) begin
          res[n].e = f.e0;
          n = n + 2'd1;
        end
        k = clrle_pkg::KIND_IDLE;
        c = '0;
      end
    end else if (k == clrle_pkg::KIND_NONZERO && rv == v) begin
      c = c + clrle_pkg::CountWidth'(1);
      if (c >= clrle_pkg::REPEAT_MAX) begin
        f = clrle_pkg::flush_f(k, c, rv);
        if (n < 2'd3) begin
          res[n].e = f.e0;
          n = n + 2'd1;
        end
        k = clrle_pkg::KIND_IDLE;
        c = '0;
      end
    end else begin
      f = clrle_pkg::flush_f(k, c, rv);
      if (f.cnt >= 2'd1 && n < 2'd3) begin
        res[n].e = f.e0;
        n = n + 2'd1;
      end
      if (f.cnt >= 2'd2 && n < 2'd3) begin
        res[n].e = f.e1;
        n = n + 2'd1;
      end
      if (n < 2'd3) begin
        res[n].e = clrle_pkg::literal_f(v);
        n = n + 2'd1;
      end
      k  = clrle_pkg::KIND_NONZERO;
      rv = v;
      c  = '0;
    end

    if (lengths.last_in) begin
      f = clrle_pkg::flush_f(k, c, rv);
      if (f.cnt >= 2'd1 && n < 2'd3) begin
        res[n].e = f.e0;
        n = n + 2'd1;
      end
      if (f.cnt >= 2'd2 && n < 2'd3) begin
        res[n].e = f.e1;
        n = n + 2'd1;
      end
      k  = clrle_pkg::KIND_IDLE;
      c  = '0;
      rv = '0;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].item_done     = 1'b1;
      res[n - 2'd1].sequence_done = lengths.last_in;
    end

    n_res          = n;
    run_kind_next  = k;
    run_count_next = c;
    run_value_next = rv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind  <= clrle_pkg::KIND_IDLE;
      run_count <= '0;
      run_value <= '0;
    end else if (accept) begin
      run_kind  <= run_kind_next;
      run_count <= run_count_next;
      run_value <= run_value_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < n_res) begin
          queue[wr_ptr + PtrW'(i)] <= res[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + PtrW'(n_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      fill <= fill + (accept ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
    end
  end

  assign symbols.valid         = (fill != '0);
  assign symbols.symbol        = queue[rd_ptr].e.symbol;
  assign symbols.extra_value   = queue[rd_ptr].e.extra_value;
  assign symbols.extra_width   = queue[rd_ptr].e.extra_width;
  assign symbols.item_done     = queue[rd_ptr].item_done;
  assign symbols.sequence_done = queue[rd_ptr].sequence_done;

endmodule
